FILE: src/lfuc_pkg.sv
// shared types and constants for the lfu cache with lru tie-break
`timescale 1ns / 1ps
package lfuc_pkg;

  localparam int          MAX_ENTRIES_DEF = 16;
  localparam logic [4:0]  CAP_RESET       = 5'd16;
  localparam logic [31:0] MISS_VALUE      = 32'hFFFF_FFFF;
  localparam logic [15:0] COUNT_MAX       = 16'hFFFF;
  localparam logic [15:0] COUNT_INSERT    = 16'd1;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_DONE   = 5'b10000
  } lfuc_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic decide;
    logic update;
  } lfuc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_fin;
    logic upd_fin;
    logic upd_req;
  } lfuc_sts_t;

endpackage

FILE: src/lfuc_ctrl.sv
// controller state machine: scan, decide, rank update pass, result strobe
`timescale 1ns / 1ps
module lfuc_ctrl
  import lfuc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output logic      out_valid,
  output lfuc_cmd_t cmd,
  input  lfuc_sts_t sts
);

  lfuc_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_fin) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_nxt = sts.upd_req ? ST_UPDATE : ST_DONE;
      end
      ST_UPDATE: begin
        if (sts.upd_fin) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = (state_r == ST_DONE);
  assign cmd.load   = (state_r == ST_IDLE) && start;
  assign cmd.scan   = (state_r == ST_SCAN);
  assign cmd.decide = (state_r == ST_DECIDE);
  assign cmd.update = (state_r == ST_UPDATE);

endmodule

FILE: src/lfuc_dpath.sv
// datapath: entry memories, valid bits, scan registers and rank update pass
`timescale 1ns / 1ps
module lfuc_dpath
  import lfuc_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lfuc_cmd_t          cmd,
  output lfuc_sts_t          sts,
  input  logic               cfg_valid,
  input  logic [4:0]         cfg_data,
  input  logic               in_cmd,
  input  logic signed [31:0] in_key,
  input  logic signed [31:0] in_value,
  output logic               out_hit,
  output logic signed [31:0] out_read_value
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = IW + 1;
  localparam int FW = $clog2(MAX_ENTRIES + 1);

  // configuration
  logic [4:0] cap_r;
  always_ff @(posedge clk) begin
    if (!rst_n)         cap_r <= CAP_RESET;
    else if (cfg_valid) cap_r <= cfg_data;
  end

  // request registers
  logic        cmd_r;
  logic [31:0] key_r, val_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_cmd;
      key_r <= 32'(in_key);
      val_r <= 32'(in_value);
    end
  end

  // sweep address and read pipeline
  logic [CW-1:0] idx_r;
  logic [IW-1:0] rd_idx_r;
  logic          pend_r;
  logic          issue;
  logic [IW-1:0] rd_addr;

  assign issue   = (cmd.scan || cmd.update) && (idx_r != CW'(MAX_ENTRIES));
  assign rd_addr = idx_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      pend_r <= issue;
      if (cmd.load || cmd.decide) idx_r <= '0;
      else if (issue)             idx_r <= idx_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (issue) rd_idx_r <= rd_addr;
  end

  // entry memories
  logic [31:0] key_mem  [MAX_ENTRIES];
  logic [31:0] data_mem [MAX_ENTRIES];
  logic [15:0] cnt_mem  [MAX_ENTRIES];
  logic [IW-1:0] rank_mem [MAX_ENTRIES];

  logic [31:0]   key_rd_r, data_rd_r;
  logic [15:0]   cnt_rd_r;
  logic [IW-1:0] rank_rd_r;

  logic [IW-1:0] slot_r, ref_rank_r;
  logic          all_r, wr_pend_r;
  logic [15:0]   new_cnt_r;

  logic          rank_we;
  logic [IW-1:0] rank_wd;

  always_ff @(posedge clk) begin
    if (issue) begin
      key_rd_r  <= key_mem[rd_addr];
      data_rd_r <= data_mem[rd_addr];
      cnt_rd_r  <= cnt_mem[rd_addr];
    end
    if (wr_pend_r) begin
      cnt_mem[slot_r] <= new_cnt_r;
      if (cmd_r == CMD_PUT) begin
        key_mem[slot_r]  <= key_r;
        data_mem[slot_r] <= val_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue)   rank_rd_r <= rank_mem[rd_addr];
    if (rank_we) rank_mem[rd_idx_r] <= rank_wd;
  end

  // valid bits and fill level
  logic [MAX_ENTRIES-1:0] valid_r;
  logic [FW-1:0]          fill_r;
  logic                   cur_valid;
  assign cur_valid = valid_r[rd_idx_r];

  // scan: key match, first free slot, least-count oldest victim
  logic          scan_ev;
  logic          hit_r, free_r, vic_r;
  logic [IW-1:0] hit_slot_r, hit_rank_r, free_slot_r, vic_slot_r, vic_rank_r;
  logic [15:0]   hit_cnt_r, vic_cnt_r;
  logic [31:0]   rdval_r;
  logic          vic_better;

  assign scan_ev    = pend_r && cmd.scan;
  assign vic_better = !vic_r || (cnt_rd_r < vic_cnt_r) ||
                      ((cnt_rd_r == vic_cnt_r) && (rank_rd_r > vic_rank_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
      vic_r  <= 1'b0;
    end else if (cmd.load) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
      vic_r  <= 1'b0;
    end else if (scan_ev) begin
      if (cur_valid && (key_rd_r == key_r) && !hit_r) hit_r <= 1'b1;
      if (!cur_valid && !free_r) free_r <= 1'b1;
      if (cur_valid && vic_better) vic_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rdval_r <= MISS_VALUE;
    end else if (scan_ev) begin
      if (cur_valid && (key_rd_r == key_r) && !hit_r) begin
        hit_slot_r <= rd_idx_r;
        hit_cnt_r  <= cnt_rd_r;
        hit_rank_r <= rank_rd_r;
        if (cmd_r == CMD_GET) rdval_r <= data_rd_r;
      end
      if (!cur_valid && !free_r) free_slot_r <= rd_idx_r;
      if (cur_valid && vic_better) begin
        vic_slot_r <= rd_idx_r;
        vic_cnt_r  <= cnt_rd_r;
        vic_rank_r <= rank_rd_r;
      end
    end
  end

  // decision
  logic [8:0]    cap9, cap_eff;
  logic          fill_lt_cap, do_upd, dec_ins, dec_all;
  logic [IW-1:0] dec_slot, dec_rank;
  logic [15:0]   dec_cnt;

  always_comb begin
    cap9        = {4'b0, cap_r};
    cap_eff     = (cap9 > 9'(MAX_ENTRIES)) ? 9'(MAX_ENTRIES) : cap9;
    fill_lt_cap = 9'(fill_r) < cap_eff;
    do_upd      = (cmd_r == CMD_GET) ? hit_r : (cap_eff != 9'd0);
    dec_ins     = 1'b0;
    dec_all     = 1'b0;
    dec_slot    = vic_slot_r;
    dec_rank    = vic_rank_r;
    dec_cnt     = COUNT_INSERT;
    if (hit_r) begin
      dec_slot = hit_slot_r;
      dec_rank = hit_rank_r;
      dec_cnt  = (hit_cnt_r == COUNT_MAX) ? hit_cnt_r : hit_cnt_r + 16'd1;
    end else if (fill_lt_cap && free_r) begin
      // insert into a free slot: every valid entry ages by one
      dec_slot = free_slot_r;
      dec_all  = 1'b1;
      dec_ins  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      slot_r     <= dec_slot;
      ref_rank_r <= dec_rank;
      all_r      <= dec_all;
      new_cnt_r  <= dec_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      fill_r    <= '0;
      wr_pend_r <= 1'b0;
    end else if (cmd.decide) begin
      wr_pend_r <= do_upd;
      if (do_upd && dec_ins) begin
        valid_r[dec_slot] <= 1'b1;
        fill_r            <= fill_r + FW'(1);
      end
    end else begin
      wr_pend_r <= 1'b0;
    end
  end

  // rank update pass: touched slot becomes newest, younger entries age (all valid ones on a free-slot insert)
  logic upd_ev;
  assign upd_ev = pend_r && cmd.update;

  always_comb begin
    rank_we = 1'b0;
    rank_wd = rank_rd_r + IW'(1);
    if (upd_ev) begin
      if (rd_idx_r == slot_r) begin
        rank_we = 1'b1;
        rank_wd = '0;
      end else if (cur_valid && (all_r || (rank_rd_r < ref_rank_r))) begin
        rank_we = 1'b1;
      end
    end
  end

  assign sts.scan_fin = scan_ev && (rd_idx_r == IW'(MAX_ENTRIES - 1));
  assign sts.upd_fin  = upd_ev && (rd_idx_r == IW'(MAX_ENTRIES - 1));
  assign sts.upd_req  = do_upd;

  assign out_hit        = hit_r;
  assign out_read_value = $signed(rdval_r);

endmodule

FILE: src/lfu_cache_lru_tiebreak.sv
// lfu cache with lru tie-break: one request scans all entries, then updates ranks,
// except for a get miss or a put at capacity zero, which skip the rank pass
// one request at a time: start is taken only while idle, and busy stays high until the result strobe
// reset clears the valid bits and fill level and sets the capacity to 16
// out_valid pulses for one cycle per request; the receiver cannot stall
`timescale 1ns / 1ps
module lfu_cache_lru_tiebreak
  import lfuc_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_cmd,
  input  logic signed [31:0] in_key,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic               out_hit,
  output logic signed [31:0] out_read_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_data
);

  lfuc_cmd_t cmd;
  lfuc_sts_t sts;

  // config transfer is taken in any cycle
  assign cfg_ready = 1'b1;

  lfuc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  lfuc_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .in_cmd         (in_cmd),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_hit        (out_hit),
    .out_read_value (out_read_value)
  );

endmodule

FILE: verif/lfu_cache_lru_tiebreak_test.sv
// self-checking testbench for the lfu cache with lru tie-break
`timescale 1ns / 1ps
module lfu_cache_lru_tiebreak_test;
  import lfuc_pkg::*;

  localparam int NE = MAX_ENTRIES_DEF;

  typedef struct {
    logic        hit;
    logic [31:0] read_value;
  } reply_t;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic        cmd;
    logic [31:0] key;
    logic [31:0] value;   // capacity on a config row
    bit          known;
    logic        hit;
    logic [31:0] read_value;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_cmd;
  logic [31:0] in_key;
  logic [31:0] in_value;
  logic        out_valid;
  logic        out_hit;
  logic [31:0] out_read_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_data;

  lfu_cache_lru_tiebreak uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_key        (in_key),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_hit       (out_hit),
    .out_read_value(out_read_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // shadow copy of the cache contents
  logic        m_valid [NE];
  logic [31:0] m_key   [NE];
  logic [31:0] m_data  [NE];
  logic [15:0] m_count [NE];
  int          m_rank  [NE];
  int          m_fill;
  logic [4:0]  m_capacity;

  reply_t pending_replies[$];
  int     errors = 0;

  stim_row_t plan [26] = '{
    '{ROW_REQ, CMD_GET, 32'h0000_0000, 32'h0000_0000, 1, 1'b0, MISS_VALUE},
    '{ROW_REQ, CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1, 1'b0, MISS_VALUE},
    '{ROW_REQ, CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1'b0, MISS_VALUE},
    '{ROW_REQ, CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1, 1'b1, 32'h8000_0000},
    '{ROW_REQ, CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1'b0, MISS_VALUE},
    '{ROW_REQ, CMD_GET, 32'h8000_0000, 32'h0000_0000, 1, 1'b1, 32'h7FFF_FFFF},
    '{ROW_REQ, CMD_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1, MISS_VALUE},
    '{ROW_REQ, CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1, 1'b1, 32'hFFFF_FFFF},
    '{ROW_REQ, CMD_PUT, 32'h0000_0000, 32'h0000_0000, 1, 1'b0, MISS_VALUE},
    '{ROW_REQ, CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF, 1, 1'b1, 32'h0000_0000},
    // capacity zero: puts leave the cache alone
    '{ROW_CFG, CMD_GET, 32'h0000_0000, 32'd0,         0, 1'b0, MISS_VALUE},
    '{ROW_REQ, CMD_PUT, 32'h0000_0000, 32'h0000_0005, 1, 1'b1, MISS_VALUE},
    '{ROW_REQ, CMD_GET, 32'h0000_0000, 32'h0000_0000, 1, 1'b1, 32'h0000_0000},
    '{ROW_REQ, CMD_PUT, 32'h1234_5678, 32'h0000_0001, 1, 1'b0, MISS_VALUE},
    '{ROW_REQ, CMD_GET, 32'h1234_5678, 32'h0000_0000, 1, 1'b0, MISS_VALUE},
    // capacity below the fill level: a miss evicts and reuses one slot
    '{ROW_CFG, CMD_GET, 32'h0000_0000, 32'd2,         0, 1'b0, MISS_VALUE},
    '{ROW_REQ, CMD_PUT, 32'hAAAA_5555, 32'h5555_AAAA, 0, 1'b0, MISS_VALUE},
    '{ROW_REQ, CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 0, 1'b0, MISS_VALUE},
    '{ROW_REQ, CMD_GET, 32'h8000_0000, 32'h0000_0000, 0, 1'b0, MISS_VALUE},
    '{ROW_REQ, CMD_GET, 32'h0000_0000, 32'h0000_0000, 0, 1'b0, MISS_VALUE},
    '{ROW_REQ, CMD_GET, 32'hAAAA_5555, 32'h0000_0000, 0, 1'b0, MISS_VALUE},
    // equal counts: the older of the two goes first
    '{ROW_CFG, CMD_GET, 32'h0000_0000, 32'd3,         0, 1'b0, MISS_VALUE},
    '{ROW_REQ, CMD_PUT, 32'h0000_0005, 32'h0000_0055, 0, 1'b0, MISS_VALUE},
    '{ROW_REQ, CMD_PUT, 32'h0000_0006, 32'h0000_0066, 0, 1'b0, MISS_VALUE},
    '{ROW_REQ, CMD_GET, 32'h0000_0005, 32'h0000_0000, 0, 1'b0, MISS_VALUE},
    '{ROW_REQ, CMD_GET, 32'h0000_0006, 32'h0000_0000, 0, 1'b0, MISS_VALUE}
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic promote_entry(input int s);
    int r;
    r = m_rank[s];
    for (int i = 0; i < NE; i++)
      if (m_valid[i] && i != s && m_rank[i] < r) m_rank[i]++;
    m_rank[s] = 0;
  endtask

  task automatic bump_entry(input int s);
    if (m_count[s] < COUNT_MAX) m_count[s]++;
    promote_entry(s);
  endtask

  task automatic predict_lookup(input logic cmd, input logic [31:0] key,
                                input logic [31:0] value, output reply_t rep);
    int slot;
    int cap;
    bit found;
    bit have_free;
    bit seen;
    slot = 0;
    found = 0;
    cap = (m_capacity > NE) ? NE : int'(m_capacity);
    for (int i = 0; i < NE; i++)
      if (!found && m_valid[i] && m_key[i] == key) begin
        found = 1;
        slot = i;
      end
    rep.hit = found;
    rep.read_value = MISS_VALUE;
    if (cmd == CMD_GET) begin
      if (found) begin
        rep.read_value = m_data[slot];
        bump_entry(slot);
      end
    end else if (cap != 0) begin
      if (found) begin
        m_data[slot] = value;
        bump_entry(slot);
      end else begin
        have_free = 0;
        if (m_fill < cap)
          for (int i = 0; i < NE; i++)
            if (!have_free && !m_valid[i]) begin
              slot = i;
              have_free = 1;
            end
        if (have_free) begin
          for (int i = 0; i < NE; i++)
            if (m_valid[i]) m_rank[i]++;
          m_rank[slot] = 0;
          m_valid[slot] = 1'b1;
          m_fill++;
        end else begin
          // lowest count, oldest among equals
          seen = 0;
          slot = 0;
          for (int i = 0; i < NE; i++)
            if (m_valid[i] && (!seen || m_count[i] < m_count[slot] ||
                (m_count[i] == m_count[slot] && m_rank[i] > m_rank[slot]))) begin
              slot = i;
              seen = 1;
            end
          promote_entry(slot);
        end
        m_key[slot] = key;
        m_data[slot] = value;
        m_count[slot] = COUNT_INSERT;
      end
    end
  endtask

  // start is left high after a transfer so back-to-back requests stay back-to-back
  task automatic send_request(input logic cmd, input logic [31:0] key,
                              input logic [31:0] value, input bit idle_ok,
                              input bit use_known, input reply_t known);
    reply_t rep;
    int gap;
    if (idle_ok && $urandom_range(0, 99) < 22) begin
      gap = $urandom_range(1, 45);
      start <= 1'b0;
      in_cmd <= 1'($urandom);
      in_key <= $urandom;
      in_value <= $urandom;
      // idle cycles count only once the block is ready again
      do @(posedge clk); while (busy);
      repeat (gap - 1) @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_key <= key;
    in_value <= value;
    do @(posedge clk); while (busy);
    predict_lookup(cmd, key, value, rep);
    pending_replies.push_back(use_known ? known : rep);
  endtask

  task automatic set_capacity(input logic [4:0] cap);
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    do @(posedge clk); while (!cfg_ready);
    m_capacity = cap;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin : reply_check
    reply_t want;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        errors++;
        $error("unexpected result: hit %0d read_value %h", out_hit, out_read_value);
      end else begin
        want = pending_replies.pop_front();
        if (out_hit !== want.hit) begin
          errors++;
          $error("hit: expected %0d, actual %0d", want.hit, out_hit);
        end
        if (out_read_value !== want.read_value) begin
          errors++;
          $error("read_value: expected %h, actual %h", want.read_value, out_read_value);
        end
      end
    end
  end

  initial begin
    reply_t      row_reply;
    reply_t      none;
    logic [31:0] key_pool [24];
    logic [4:0]  phase_caps [10];
    logic [31:0] sat_key;
    logic [31:0] k;
    int          span;
    int          waited;

    clk = 1'b0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_cmd <= CMD_GET;
    in_key <= '0;
    in_value <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    none = '{1'b0, MISS_VALUE};
    for (int i = 0; i < NE; i++) begin
      m_valid[i] = 1'b0;
      m_key[i] = '0;
      m_data[i] = '0;
      m_count[i] = '0;
      m_rank[i] = 0;
    end
    m_fill = 0;
    m_capacity = CAP_RESET;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        set_capacity(plan[r].value[4:0]);
      end else begin
        row_reply = '{plan[r].hit, plan[r].read_value};
        send_request(plan[r].cmd, plan[r].key, plan[r].value, 1'b1,
                     plan[r].known, row_reply);
      end
    end

    // build up one entry's count, then let misses compete with it
    set_capacity(5'd2);
    sat_key = $urandom;
    send_request(CMD_PUT, sat_key, $urandom, 1'b0, 1'b0, none);
    repeat (40) send_request(CMD_GET, sat_key, $urandom, 1'b0, 1'b0, none);
    set_capacity(5'd16);
    repeat (18) begin
      send_request(CMD_PUT, $urandom, $urandom, 1'b0, 1'b0, none);
      send_request(CMD_GET, sat_key, $urandom, 1'b0, 1'b0, none);
    end

    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    phase_caps = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd3, 5'd8, 5'd20, 5'd2, 5'd0, 5'd16};
    phase_caps[8] = 5'($urandom_range(0, 31));

    for (int p = 0; p < 10; p++) begin
      set_capacity(phase_caps[p]);
      span = ((phase_caps[p] > NE) ? NE : int'(phase_caps[p])) + 4;
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, span - 1)];
        else k = $urandom;
        // phase four runs without any idle cycles
        send_request(1'($urandom_range(0, 1)), k, $urandom, p != 4, 1'b0, none);
      end
    end

    start <= 1'b0;
    waited = 0;
    while (pending_replies.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * NE + 8) @(posedge clk);
    if (pending_replies.size() != 0) begin
      errors++;
      $error("%0d results never arrived", pending_replies.size());
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
